@@ rtl/circle_hough_vote_accumulator_macros.svh @@
// assertion macros for the circle hough vote accumulator
// used by the top level only, no other dependencies
`ifndef CIRCLE_HOUGH_VOTE_ACCUMULATOR_MACROS_SVH
`define CIRCLE_HOUGH_VOTE_ACCUMULATOR_MACROS_SVH
`ifndef SYNTHESIS
`define CHVA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");
`define CHVA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");
`else
`define CHVA_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define CHVA_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ rtl/chva_pkg.sv @@
// shared types, codes and trig tables of the circle hough vote accumulator
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package chva_pkg;

	localparam int ANGLES       = 360;
	localparam int TESTED_RADII = 14;
	localparam int ANGW         = 9;
	localparam int RADW         = 9;
	localparam int TRIGW        = 16;
	localparam int FRAC         = 14;
	localparam int PW           = 26;
	localparam int CW           = PW - FRAC;
	localparam int PIXW         = 10;
	localparam int CELLW_IN     = 8;
	localparam int KIW          = 4;
	localparam int GREYW        = 8;
	localparam int OUTW         = 16;
	localparam int CFG_IW       = 8;
	localparam int CFG_DW       = 8;
	localparam int QUEUE_DEPTH  = 4;

	localparam logic             REQ_VOTE   = 1'b0;
	localparam logic             REQ_READ   = 1'b1;
	localparam logic [GREYW-1:0] EDGE_VALUE = 8'd255;

	localparam logic [CFG_IW-1:0] CFG_RADIUS_MIN  = 8'd0;
	localparam logic [CFG_IW-1:0] CFG_RADIUS_STEP = 8'd1;
	localparam logic [7:0]        RADIUS_MIN_RST  = 8'd15;
	localparam logic [3:0]        RADIUS_STEP_RST = 4'd2;

	localparam longint Q30_ONE  = longint'(1) << 30;
	localparam longint Q30_HALF = longint'(1) << 29;

	typedef struct packed {
		logic            is_read;
		logic            ok;
		logic [PIXW-1:0] px;
		logic [PIXW-1:0] py;
		logic [KIW-1:0]  k;
	} work_entry_t;

	typedef logic signed [TRIGW-1:0] trig_tab_t [ANGLES];

	function automatic longint q30_mul(input longint p, input longint q);
		longint m;
		m = p * q;
		if (m >= 0)
			return (m + Q30_HALF) / Q30_ONE;
		return -((-m + Q30_HALF) / Q30_ONE);
	endfunction

	function automatic int q30_to_q14(input longint v);
		if (v >= 0)
			return int'((v + 32768) >>> 16);
		return -int'((-v + 32768) >>> 16);
	endfunction

	// rotation by one step of 3.14/180 rad in q2.30
	function automatic trig_tab_t build_trig(input bit want_sin);
		longint d, d2, d3, d4, d5, cd, sd, c, s, nc, ns;
		trig_tab_t tab;
		d  = (314 * Q30_ONE + 9000) / 18000;
		d2 = q30_mul(d, d);
		d3 = q30_mul(d2, d);
		d4 = q30_mul(d3, d);
		d5 = q30_mul(d4, d);
		cd = Q30_ONE - d2 / 2 + d4 / 24;
		sd = d - d3 / 6 + d5 / 120;
		c  = Q30_ONE;
		s  = 0;
		for (int i = 0; i < ANGLES; i++) begin
			tab[i] = want_sin ? TRIGW'(q30_to_q14(s)) : TRIGW'(q30_to_q14(c));
			nc = q30_mul(c, cd) - q30_mul(s, sd);
			ns = q30_mul(s, cd) + q30_mul(c, sd);
			c  = nc;
			s  = ns;
		end
		return tab;
	endfunction

	localparam trig_tab_t COS_TAB = build_trig(1'b0);
	localparam trig_tab_t SIN_TAB = build_trig(1'b1);

endpackage

@@ rtl/chva_queue.sv @@
// short work queue between the front and back parts
// depends on chva_pkg for the entry type and depth
`timescale 1ns / 1ps

module chva_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  chva_pkg::work_entry_t push_entry,
	input  logic                  pop,
	output chva_pkg::work_entry_t head,
	output logic                  full,
	output logic                  empty
);
	import chva_pkg::*;

	localparam int PTRW = $clog2(QUEUE_DEPTH);
	localparam int CNTW = $clog2(QUEUE_DEPTH + 1);

	work_entry_t         slot_q [QUEUE_DEPTH];
	logic [PTRW-1:0]     wr_ptr_q;
	logic [PTRW-1:0]     rd_ptr_q;
	logic [CNTW-1:0]     fill_q;
	logic                do_push;
	logic                do_pop;

	assign full    = fill_q == CNTW'(QUEUE_DEPTH);
	assign empty   = fill_q == '0;
	assign head    = slot_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				fill_q <= fill_q + 1'b1;
			else if (do_pop && !do_push)
				fill_q <= fill_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			slot_q[wr_ptr_q] <= push_entry;
	end

endmodule

@@ rtl/chva_front.sv @@
// front part: input transfer and classification into work entries
// depends on chva_pkg for the entry type and request codes
`timescale 1ns / 1ps

module chva_front #(
	parameter int ACC_ROWS  = 256,
	parameter int ACC_COLS  = 256,
	parameter int NUM_RADII = 16
) (
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           req_type,
	input  logic [chva_pkg::PIXW-1:0]      pixel_x,
	input  logic [chva_pkg::PIXW-1:0]      pixel_y,
	input  logic [chva_pkg::GREYW-1:0]     pixel_value,
	input  logic [chva_pkg::CELLW_IN-1:0]  cell_a,
	input  logic [chva_pkg::CELLW_IN-1:0]  cell_b,
	input  logic [chva_pkg::KIW-1:0]       cell_radius_index,
	input  logic                           clearing,
	input  logic                           q_full,
	output logic                           push,
	output chva_pkg::work_entry_t          entry
);
	import chva_pkg::*;

	logic accept;
	logic read_ok;

	assign in_ready = !clearing && !q_full;
	assign accept   = in_valid && in_ready;
	assign read_ok  = (int'(cell_a) < ACC_ROWS) && (int'(cell_b) < ACC_COLS)
		&& (int'(cell_radius_index) < NUM_RADII);

	// non-edge pixels vote nothing and are dropped here
	assign push = accept && (req_type == REQ_READ || pixel_value == EDGE_VALUE);

	// reads carry the cell coordinates in the pixel slots
	always_comb begin
		entry.is_read = req_type == REQ_READ;
		if (req_type == REQ_READ) begin
			entry.ok = read_ok;
			entry.px = PIXW'(cell_a);
			entry.py = PIXW'(cell_b);
			entry.k  = cell_radius_index;
		end else begin
			entry.ok = 1'b1;
			entry.px = pixel_x;
			entry.py = pixel_y;
			entry.k  = '0;
		end
	end

endmodule

@@ rtl/chva_back.sv @@
// back part: vote sequencer, center pipeline and count store
// depends on chva_pkg for trig tables, widths and the entry type
`timescale 1ns / 1ps

module chva_back #(
	parameter int ACC_ROWS    = 256,
	parameter int ACC_COLS    = 256,
	parameter int NUM_RADII   = 16,
	parameter int COUNT_WIDTH = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [7:0]                  radius_min,
	input  logic [3:0]                  radius_step,
	input  chva_pkg::work_entry_t       head,
	input  logic                        q_empty,
	output logic                        q_pop,
	output logic                        clearing,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [chva_pkg::OUTW-1:0]   vote_count
);
	import chva_pkg::*;

	localparam int DEPTH  = ACC_ROWS * ACC_COLS * NUM_RADII;
	localparam int AW     = $clog2(DEPTH);
	localparam int CELLS  = ACC_ROWS * ACC_COLS;
	localparam int CELLW  = $clog2(CELLS);
	localparam int RW     = $clog2(ACC_ROWS);
	localparam int CBW    = $clog2(ACC_COLS);
	localparam int KW     = $clog2(NUM_RADII);
	localparam int KCOUNT = (TESTED_RADII < NUM_RADII) ? TESTED_RADII : NUM_RADII;
	localparam logic [ANGW-1:0] ANG_LAST = ANGW'(ANGLES - 1);
	localparam logic [KW-1:0]   K_LAST   = KW'(KCOUNT - 1);
	localparam logic [AW-1:0]   CLR_LAST = AW'(DEPTH - 1);

	typedef enum logic [2:0] {
		ST_CLEAR = 3'b001,
		ST_IDLE  = 3'b010,
		ST_VOTE  = 3'b100
	} seq_state_t;

	seq_state_t              state_q, state_d;
	logic [ANGW-1:0]         ang_q;
	logic [KW-1:0]           k_q;
	logic [RADW-1:0]         r_q;
	logic [PIXW-1:0]         cur_x_q, cur_y_q;
	logic [AW-1:0]           clr_q;
	logic                    rd_busy_q;
	logic                    out_vld_q;
	logic [OUTW-1:0]         out_cnt_q;

	logic                    iss_vld, iss_rd, iss_ok;
	logic [PIXW-1:0]         iss_px, iss_py;
	logic [KW-1:0]           iss_k;
	logic                    last_vote;
	logic                    start_vote;

	logic                    vld_s1, rd_s1, ok_s1;
	logic [PIXW-1:0]         px_s1, py_s1;
	logic [KW-1:0]           k_s1;
	logic [RADW-1:0]         r_s1;
	logic signed [TRIGW-1:0] cos_s1, sin_s1;

	logic                    vld_s2, rd_s2, ok_s2;
	logic [PIXW-1:0]         px_s2, py_s2;
	logic [KW-1:0]           k_s2;
	logic signed [PW-1:0]    prod_a_s2, prod_b_s2;

	logic                    vld_s3, rd_s3, ok_s3;
	logic [KW-1:0]           k_s3;
	logic signed [CW-1:0]    a_s3, b_s3;
	logic signed [PW-1:0]    num_a, num_b;

	logic                    vld_s4, rd_s4, keep_s4;
	logic [KW-1:0]           k_s4;
	logic [CELLW-1:0]        cell_s4;
	logic                    vote_in_range;

	logic                    vld_s5, rd_s5, keep_s5;
	logic [AW-1:0]           addr_s5;

	logic                    vld_s6, rd_s6, keep_s6;
	logic [AW-1:0]           addr_s6;
	logic [COUNT_WIDTH-1:0]  rdata_s6;
	logic                    fwd_hit_s6;
	logic [COUNT_WIDTH-1:0]  fwd_data_s6;
	logic [COUNT_WIDTH-1:0]  old_cnt, inc_cnt;

	logic                    mem_we;
	logic [AW-1:0]           mem_waddr;
	logic [COUNT_WIDTH-1:0]  mem_wdata;
	logic [COUNT_WIDTH-1:0]  store_mem [DEPTH];

	assign clearing   = state_q == ST_CLEAR;
	assign last_vote  = ang_q == ANG_LAST && k_q == K_LAST;
	assign out_valid  = out_vld_q;
	assign vote_count = out_cnt_q;

	// sequencer
	always_comb begin
		state_d    = state_q;
		q_pop      = 1'b0;
		start_vote = 1'b0;
		iss_vld    = 1'b0;
		iss_rd     = 1'b0;
		iss_ok     = 1'b1;
		iss_px     = cur_x_q;
		iss_py     = cur_y_q;
		iss_k      = k_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_q == CLR_LAST)
					state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (!q_empty) begin
					if (head.is_read) begin
						if (!out_vld_q && !rd_busy_q) begin
							q_pop   = 1'b1;
							iss_vld = 1'b1;
							iss_rd  = 1'b1;
							iss_ok  = head.ok;
							iss_px  = head.px;
							iss_py  = head.py;
							iss_k   = KW'(head.k);
						end
					end else begin
						q_pop      = 1'b1;
						start_vote = 1'b1;
						state_d    = ST_VOTE;
					end
				end
			end
			ST_VOTE: begin
				iss_vld = 1'b1;
				if (last_vote)
					state_d = ST_IDLE;
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_q     <= '0;
			ang_q     <= '0;
			k_q       <= '0;
			rd_busy_q <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (clearing)
				clr_q <= clr_q + 1'b1;
			if (start_vote) begin
				ang_q <= '0;
				k_q   <= '0;
			end else if (state_q == ST_VOTE) begin
				if (ang_q == ANG_LAST) begin
					ang_q <= '0;
					k_q   <= k_q + 1'b1;
				end else begin
					ang_q <= ang_q + 1'b1;
				end
			end
			if (iss_vld && iss_rd)
				rd_busy_q <= 1'b1;
			else if (vld_s6 && rd_s6)
				rd_busy_q <= 1'b0;
			if (vld_s6 && rd_s6)
				out_vld_q <= 1'b1;
			else if (out_ready)
				out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start_vote) begin
			cur_x_q <= head.px;
			cur_y_q <= head.py;
			r_q     <= RADW'(radius_min);
		end else if (state_q == ST_VOTE && ang_q == ANG_LAST) begin
			r_q <= r_q + RADW'(radius_step);
		end
		if (vld_s6 && rd_s6)
			out_cnt_q <= OUTW'(keep_s6 ? old_cnt : '0);
	end

	// valid bits of the pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else begin
			vld_s1 <= iss_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	assign num_a = $signed({2'b00, px_s2, {FRAC{1'b0}}}) - prod_a_s2;
	assign num_b = $signed({2'b00, py_s2, {FRAC{1'b0}}}) - prod_b_s2;
	assign vote_in_range = (a_s3 > 0) && (int'(a_s3) < ACC_ROWS)
		&& (b_s3 > 0) && (int'(b_s3) < ACC_COLS);

	always_ff @(posedge clk) begin
		// s1: table read
		rd_s1  <= iss_rd;
		ok_s1  <= iss_ok;
		px_s1  <= iss_px;
		py_s1  <= iss_py;
		k_s1   <= iss_k;
		r_s1   <= r_q;
		cos_s1 <= COS_TAB[ang_q];
		sin_s1 <= SIN_TAB[ang_q];
		// s2: radius times cos and sin
		rd_s2     <= rd_s1;
		ok_s2     <= ok_s1;
		px_s2     <= px_s1;
		py_s2     <= py_s1;
		k_s2      <= k_s1;
		prod_a_s2 <= $signed({1'b0, r_s1}) * cos_s1;
		prod_b_s2 <= $signed({1'b0, r_s1}) * sin_s1;
		// s3: center by floor of the q14 difference
		rd_s3 <= rd_s2;
		ok_s3 <= ok_s2;
		k_s3  <= k_s2;
		a_s3  <= rd_s2 ? $signed(CW'(px_s2)) : num_a[PW-1:FRAC];
		b_s3  <= rd_s2 ? $signed(CW'(py_s2)) : num_b[PW-1:FRAC];
		// s4: range check and cell index
		rd_s4   <= rd_s3;
		k_s4    <= k_s3;
		keep_s4 <= rd_s3 ? ok_s3 : vote_in_range;
		cell_s4 <= CELLW'(32'(a_s3[RW-1:0]) * ACC_COLS + 32'(b_s3[CBW-1:0]));
		// s5: store address
		rd_s5   <= rd_s4;
		keep_s5 <= keep_s4;
		addr_s5 <= AW'(32'(cell_s4) * NUM_RADII + 32'(k_s4));
		// s6: store read, bypass of the write landing at the same edge
		rd_s6       <= rd_s5;
		keep_s6     <= keep_s5;
		addr_s6     <= addr_s5;
		fwd_hit_s6  <= mem_we && mem_waddr == addr_s5;
		fwd_data_s6 <= mem_wdata;
	end

	assign old_cnt   = fwd_hit_s6 ? fwd_data_s6 : rdata_s6;
	assign inc_cnt   = (&old_cnt) ? old_cnt : old_cnt + 1'b1;
	assign mem_we    = clearing || (vld_s6 && !rd_s6 && keep_s6);
	assign mem_waddr = clearing ? clr_q : addr_s6;
	assign mem_wdata = clearing ? '0 : inc_cnt;

	always_ff @(posedge clk) begin
		if (mem_we)
			store_mem[mem_waddr] <= mem_wdata;
		rdata_s6 <= store_mem[addr_s5];
	end

endmodule

@@ rtl/circle_hough_vote_accumulator.sv @@
// edge pixel: dequeued, then the vote sequencer sweeps 360 angles x 14 radii
// (fewer radii when NUM_RADII < 14), one store read-modify-write per cycle
// read request: issued from the queue when the back part is idle; its count is registered after stage s6
// reset: radius_min 15, radius_step 2; then a clearing pass over all
// ACC_ROWS*ACC_COLS*NUM_RADII store words (1048576 by default) with in_ready low
`timescale 1ns / 1ps
`include "circle_hough_vote_accumulator_macros.svh"

module circle_hough_vote_accumulator #(
	parameter int ACC_ROWS    = 256,
	parameter int ACC_COLS    = 256,
	parameter int NUM_RADII   = 16,
	parameter int COUNT_WIDTH = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [chva_pkg::CFG_IW-1:0]    cfg_index,
	input  logic [chva_pkg::CFG_DW-1:0]    cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           req_type,
	input  logic [chva_pkg::PIXW-1:0]      pixel_x,
	input  logic [chva_pkg::PIXW-1:0]      pixel_y,
	input  logic [chva_pkg::GREYW-1:0]     pixel_value,
	input  logic [chva_pkg::CELLW_IN-1:0]  cell_a,
	input  logic [chva_pkg::CELLW_IN-1:0]  cell_b,
	input  logic [chva_pkg::KIW-1:0]       cell_radius_index,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [chva_pkg::OUTW-1:0]      vote_count
);
	import chva_pkg::*;

	logic [7:0]  radius_min_q;
	logic [3:0]  radius_step_q;
	logic        clearing;
	logic        q_push, q_pop, q_full, q_empty;
	work_entry_t q_in, q_head;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_min_q  <= RADIUS_MIN_RST;
			radius_step_q <= RADIUS_STEP_RST;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == CFG_RADIUS_MIN)
				radius_min_q <= cfg_data;
			else if (cfg_index == CFG_RADIUS_STEP)
				radius_step_q <= cfg_data[3:0];
		end
	end

	chva_front #(
		.ACC_ROWS  (ACC_ROWS),
		.ACC_COLS  (ACC_COLS),
		.NUM_RADII (NUM_RADII)
	) u_front (
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.req_type          (req_type),
		.pixel_x           (pixel_x),
		.pixel_y           (pixel_y),
		.pixel_value       (pixel_value),
		.cell_a            (cell_a),
		.cell_b            (cell_b),
		.cell_radius_index (cell_radius_index),
		.clearing          (clearing),
		.q_full            (q_full),
		.push              (q_push),
		.entry             (q_in)
	);

	chva_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (q_in),
		.pop        (q_pop),
		.head       (q_head),
		.full       (q_full),
		.empty      (q_empty)
	);

	chva_back #(
		.ACC_ROWS    (ACC_ROWS),
		.ACC_COLS    (ACC_COLS),
		.NUM_RADII   (NUM_RADII),
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.radius_min  (radius_min_q),
		.radius_step (radius_step_q),
		.head        (q_head),
		.q_empty     (q_empty),
		.q_pop       (q_pop),
		.clearing    (clearing),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.vote_count  (vote_count)
	);

	`CHVA_ASSERT_IMP(a_no_transfer_in_clear, clk, arst_n, clearing, !in_ready)
	`CHVA_ASSERT_NXT(a_clear_only_after_reset, clk, arst_n, !clearing, !clearing)
	`CHVA_ASSERT_IMP(a_no_push_when_full, clk, arst_n, q_push, !q_full)
	`CHVA_ASSERT_IMP(a_no_pop_when_empty, clk, arst_n, q_pop, !q_empty)

endmodule

@@ sim/circle_hough_vote_accumulator_tb.sv @@
`timescale 1ns / 1ps
// testbench for circle_hough_vote_accumulator: edge pixel votes and cell reads under
// several radius settings, idles and stalls; cell counts come from a local vote store
// depends on chva_pkg and the rtl of the block only

module circle_hough_vote_accumulator_tb;

	localparam int ROWS = 256;
	localparam int COLS = 256;
	localparam int NRAD = 16;
	localparam int CNTW = 16;

	localparam int RING_ANGLES = 360;
	localparam int RING_RADII  = 14;
	localparam int FX_FRAC     = 14;
	localparam longint FX_ONE  = longint'(1) << 30;
	localparam longint FX_HALF = longint'(1) << 29;
	localparam int unsigned COUNT_TOP = unsigned'(32'((longint'(1) << CNTW) - 1));

	localparam int VOTE_CYCLES   = 5041;
	localparam int SETTLE_CYCLES = (chva_pkg::QUEUE_DEPTH + 2) * VOTE_CYCLES + 64;
	localparam int STALL_LIMIT   = 3 * ROWS * COLS * NRAD;
	localparam int HOLD_CYCLES   = 400;
	localparam int HOT_MAX       = 400;

	localparam logic [chva_pkg::CFG_IW-1:0] CFG_IDX_SPARE = 8'd2;
	localparam logic [chva_pkg::CFG_IW-1:0] CFG_IDX_TOP   = 8'hFF;

	typedef struct packed {
		logic                          req;
		logic [chva_pkg::PIXW-1:0]     x;
		logic [chva_pkg::PIXW-1:0]     y;
		logic [chva_pkg::GREYW-1:0]    grey;
		logic [chva_pkg::CELLW_IN-1:0] a;
		logic [chva_pkg::CELLW_IN-1:0] b;
		logic [chva_pkg::KIW-1:0]      k;
	} hough_req_t;

	typedef struct packed {
		logic [chva_pkg::OUTW-1:0]     count;
		logic [chva_pkg::CELLW_IN-1:0] a;
		logic [chva_pkg::CELLW_IN-1:0] b;
		logic [chva_pkg::KIW-1:0]      k;
	} cell_count_t;

	logic                          clk = 1'b0;
	logic                          arst_n;
	logic                          cfg_valid;
	logic                          cfg_ready;
	logic [chva_pkg::CFG_IW-1:0]   cfg_index;
	logic [chva_pkg::CFG_DW-1:0]   cfg_data;
	logic                          in_valid;
	logic                          in_ready;
	logic                          req_type;
	logic [chva_pkg::PIXW-1:0]     pixel_x;
	logic [chva_pkg::PIXW-1:0]     pixel_y;
	logic [chva_pkg::GREYW-1:0]    pixel_value;
	logic [chva_pkg::CELLW_IN-1:0] cell_a;
	logic [chva_pkg::CELLW_IN-1:0] cell_b;
	logic [chva_pkg::KIW-1:0]      cell_radius_index;
	logic                          out_valid;
	logic                          out_ready;
	logic [chva_pkg::OUTW-1:0]     vote_count;

	int          cos_q14 [RING_ANGLES];
	int          sin_q14 [RING_ANGLES];
	int unsigned cell_votes [int unsigned];
	int unsigned hot_cells [$];
	cell_count_t expected_counts [$];
	logic [7:0]  rmin_model;
	logic [3:0]  step_model;

	int     errors    = 0;
	int     n_items   = 0;
	int     n_edges   = 0;
	int     n_reads   = 0;
	int     n_nonzero = 0;
	longint cyc       = 0;
	longint last_edge_cyc = -longint'(SETTLE_CYCLES);
	int     idle_run  = 0;
	int     stall_left = 0;
	bit     jitter_on = 1'b1;

	circle_hough_vote_accumulator #(
		.ACC_ROWS(ROWS),
		.ACC_COLS(COLS),
		.NUM_RADII(NRAD),
		.COUNT_WIDTH(CNTW)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.req_type(req_type),
		.pixel_x(pixel_x),
		.pixel_y(pixel_y),
		.pixel_value(pixel_value),
		.cell_a(cell_a),
		.cell_b(cell_b),
		.cell_radius_index(cell_radius_index),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.vote_count(vote_count)
	);

	always #4 clk = ~clk;

	function automatic longint mul_q30(input longint p, input longint q);
		longint m;
		m = p * q;
		if (m >= 0)
			return (m + FX_HALF) / FX_ONE;
		return -((-m + FX_HALF) / FX_ONE);
	endfunction

	function automatic int to_q14(input longint v);
		if (v >= 0)
			return int'((v + 32768) >>> 16);
		return -int'((-v + 32768) >>> 16);
	endfunction

	// unit vector stepped around the circle by repeated rotation
	function automatic void build_rotation_tables();
		longint d, d2, d3, d4, d5, cstep, sstep, c, s, nc;
		d  = (314 * FX_ONE + 9000) / 18000;
		d2 = mul_q30(d, d);
		d3 = mul_q30(d2, d);
		d4 = mul_q30(d3, d);
		d5 = mul_q30(d4, d);
		cstep = FX_ONE - d2 / 2 + d4 / 24;
		sstep = d - d3 / 6 + d5 / 120;
		c = FX_ONE;
		s = 0;
		for (int i = 0; i < RING_ANGLES; i++) begin
			cos_q14[i] = to_q14(c);
			sin_q14[i] = to_q14(s);
			nc = mul_q30(c, cstep) - mul_q30(s, sstep);
			s  = mul_q30(s, cstep) + mul_q30(c, sstep);
			c  = nc;
		end
	endfunction

	function automatic int unsigned cell_key(input int a, input int b, input int k);
		return unsigned'((a * COLS + b) * NRAD + k);
	endfunction

	function automatic int unsigned count_of(input int a, input int b, input int k);
		if (a < ROWS && b < COLS && k < NRAD && cell_votes.exists(cell_key(a, b, k)))
			return cell_votes[cell_key(a, b, k)];
		return 0;
	endfunction

	function automatic void cast_ring_votes(input int px, input int py);
		longint r, ca, cb;
		int unsigned key;
		for (int k = 0; k < RING_RADII && k < NRAD; k++) begin
			r = longint'(rmin_model) + longint'(k) * longint'(step_model);
			for (int i = 0; i < RING_ANGLES; i++) begin
				ca = ((longint'(px) <<< FX_FRAC) - r * cos_q14[i]) >>> FX_FRAC;
				cb = ((longint'(py) <<< FX_FRAC) - r * sin_q14[i]) >>> FX_FRAC;
				if (ca <= 0 || ca >= ROWS || cb <= 0 || cb >= COLS)
					continue;
				key = cell_key(int'(ca), int'(cb), k);
				if (!cell_votes.exists(key)) begin
					cell_votes[key] = 0;
					hot_cells.push_back(key);
					if (hot_cells.size() > HOT_MAX)
						hot_cells.delete($urandom_range(hot_cells.size() - 1));
				end
				if (cell_votes[key] < COUNT_TOP)
					cell_votes[key]++;
			end
		end
	endfunction

	function automatic hough_req_t make_vote(input int x, input int y, input int grey);
		hough_req_t r;
		r.req  = chva_pkg::REQ_VOTE;
		r.x    = 10'(x);
		r.y    = 10'(y);
		r.grey = 8'(grey);
		r.a    = 8'($urandom_range(255));
		r.b    = 8'($urandom_range(255));
		r.k    = 4'($urandom_range(15));
		return r;
	endfunction

	function automatic hough_req_t make_read(input int a, input int b, input int k);
		hough_req_t r;
		r.req  = chva_pkg::REQ_READ;
		r.x    = 10'($urandom_range(1023));
		r.y    = 10'($urandom_range(1023));
		r.grey = 8'($urandom_range(255));
		r.a    = 8'(a);
		r.b    = 8'(b);
		r.k    = 4'(k);
		return r;
	endfunction

	function automatic hough_req_t hot_read();
		int unsigned key;
		if (hot_cells.size() == 0)
			return make_read($urandom_range(255), $urandom_range(255), $urandom_range(15));
		key = hot_cells[$urandom_range(hot_cells.size() - 1)];
		return make_read(key / (COLS * NRAD), (key / NRAD) % COLS, key % NRAD);
	endfunction

	function automatic hough_req_t random_req();
		int pick;
		pick = $urandom_range(99);
		if (pick < 38)
			return hot_read();
		if (pick < 55)
			return make_read($urandom_range(255), $urandom_range(255), $urandom_range(15));
		if (pick < 70) begin
			if ($urandom_range(4) == 0)
				return make_vote($urandom_range(1023), $urandom_range(1023),
					chva_pkg::EDGE_VALUE);
			return make_vote($urandom_range(320), $urandom_range(320), chva_pkg::EDGE_VALUE);
		end
		return make_vote($urandom_range(1023), $urandom_range(1023), $urandom_range(254));
	endfunction

	task automatic send_req(input hough_req_t r);
		cell_count_t e;
		while (jitter_on && $urandom_range(99) < 18) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid          <= 1'b1;
		req_type          <= r.req;
		pixel_x           <= r.x;
		pixel_y           <= r.y;
		pixel_value       <= r.grey;
		cell_a            <= r.a;
		cell_b            <= r.b;
		cell_radius_index <= r.k;
		do @(posedge clk); while (!in_ready);
		n_items++;
		if (r.req == chva_pkg::REQ_READ) begin
			e.count = 16'(count_of(int'(r.a), int'(r.b), int'(r.k)));
			e.a     = r.a;
			e.b     = r.b;
			e.k     = r.k;
			expected_counts.push_back(e);
			if (e.count != 0)
				n_nonzero++;
		end else if (r.grey == chva_pkg::EDGE_VALUE) begin
			cast_ring_votes(int'(r.x), int'(r.y));
			n_edges++;
			last_edge_cyc = cyc;
		end
	endtask

	task automatic put_reg(input logic [chva_pkg::CFG_IW-1:0] idx,
			input logic [chva_pkg::CFG_DW-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		if (idx == chva_pkg::CFG_RADIUS_MIN)
			rmin_model = val;
		else if (idx == chva_pkg::CFG_RADIUS_STEP)
			step_model = val[3:0];
	endtask

	task automatic write_radii(input logic [7:0] rmin, input logic [7:0] step);
		put_reg(chva_pkg::CFG_RADIUS_MIN, rmin);
		put_reg(chva_pkg::CFG_RADIUS_STEP, step);
		cfg_valid <= 1'b0;
	endtask

	// no reads pending and the vote sequencer has had time to finish its queue
	task automatic quiesce();
		if (in_valid)
			in_valid <= 1'b0;
		while (expected_counts.size() != 0) @(posedge clk);
		while (cyc - last_edge_cyc < SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic test_empty_store_defaults();
		send_req(make_read(0, 0, 0));
		send_req(make_read(255, 255, 15));
		send_req(make_vote(1023, 1023, 254));
		send_req(make_vote(0, 0, 0));
		send_req(make_vote(100, 120, chva_pkg::EDGE_VALUE));
		send_req(make_vote(0, 0, chva_pkg::EDGE_VALUE));
		send_req(make_vote(1023, 1023, chva_pkg::EDGE_VALUE));
		send_req(make_read(85, 120, 0));
		send_req(make_read(85, 120, 14));
		repeat (2) send_req(hot_read());
	endtask

	task automatic test_register_extremes();
		quiesce();
		put_reg(chva_pkg::CFG_RADIUS_MIN, 8'hFF);
		put_reg(chva_pkg::CFG_RADIUS_STEP, 8'hFF);
		// unmapped indexes must leave both radii alone
		put_reg(CFG_IDX_SPARE, 8'h01);
		put_reg(CFG_IDX_TOP, 8'h5A);
		cfg_valid <= 1'b0;
		send_req(make_vote(400, 300, chva_pkg::EDGE_VALUE));
		send_req(make_vote(600, 500, chva_pkg::EDGE_VALUE));
		send_req(make_read(145, 300 - 256, 0));
		repeat (3) send_req(hot_read());
	endtask

	task automatic test_zero_radius();
		quiesce();
		write_radii(8'd0, 8'd0);
		send_req(make_vote(50, 60, chva_pkg::EDGE_VALUE));
		send_req(make_vote(50, 60, chva_pkg::EDGE_VALUE));
		send_req(make_vote(0, 77, chva_pkg::EDGE_VALUE));
		send_req(make_vote(255, 255, chva_pkg::EDGE_VALUE));
		send_req(make_read(50, 60, 0));
		send_req(make_read(50, 60, 13));
		send_req(make_read(50, 60, 14));
		send_req(make_read(255, 255, 5));
	endtask

	task automatic test_backpressure();
		stall_left = HOLD_CYCLES;
		repeat (20) send_req(hot_read());
		quiesce();
	endtask

	task automatic run_random_phase(input logic [7:0] rmin, input logic [7:0] step,
			input int n, input bit steady);
		quiesce();
		write_radii(rmin, step);
		jitter_on = !steady;
		repeat (n) send_req(random_req());
		jitter_on = 1'b1;
	endtask

	task automatic test_random_sweep();
		run_random_phase(8'd1, 8'd1, 30, 1'b1);
		run_random_phase(8'($urandom_range(60, 1)), 8'($urandom_range(15, 1)), 18, 1'b0);
		run_random_phase(8'($urandom_range(120, 2)), 8'($urandom_range(15)), 18, 1'b0);
	endtask

	// result sink with random idles and a counted hold-off
	initial begin
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else begin
				out_ready <= !(jitter_on && $urandom_range(99) < 18);
			end
		end
	end

	always @(posedge clk) begin
		cell_count_t e;
		if (arst_n && out_valid && out_ready) begin
			if (expected_counts.size() == 0) begin
				errors++;
				$display("%0t: vote_count transfer %0d with no read pending", $time, vote_count);
			end else begin
				e = expected_counts.pop_front();
				n_reads++;
				if (vote_count !== e.count) begin
					errors++;
					$display("%0t: cell (%0d,%0d,%0d) vote_count expected %0d actual %0d",
						$time, e.a, e.b, e.k, e.count, vote_count);
				end
			end
		end
	end

	always @(posedge clk) begin
		cyc <= cyc + 1;
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
			idle_run <= 0;
		end else if (idle_run >= STALL_LIMIT) begin
			$display("%0t: no transfer for %0d cycles", $time, idle_run);
			$display("TEST FAILED");
			$finish;
		end else begin
			idle_run <= idle_run + 1;
		end
	end

	initial begin
		build_rotation_tables();
		rmin_model = chva_pkg::RADIUS_MIN_RST;
		step_model = chva_pkg::RADIUS_STEP_RST;
		arst_n            <= 1'b0;
		cfg_valid         <= 1'b0;
		cfg_index         <= '0;
		cfg_data          <= '0;
		in_valid          <= 1'b0;
		req_type          <= chva_pkg::REQ_VOTE;
		pixel_x           <= '0;
		pixel_y           <= '0;
		pixel_value       <= '0;
		cell_a            <= '0;
		cell_b            <= '0;
		cell_radius_index <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		test_empty_store_defaults();
		test_register_extremes();
		test_zero_radius();
		test_backpressure();
		test_random_sweep();

		quiesce();
		$display("sent %0d requests incl. %0d edge pixels across reset, extreme, zero and random radii",
			n_items, n_edges);
		$display("checked %0d cell reads, %0d with votes expected", n_reads, n_nonzero);
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
